// ----- rtl/core/cbd_pkg.sv -----
package cbd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;

    localparam logic [1:0]  MODE_RESET   = 2'd1;
    localparam logic [15:0] OFFSET_RESET = 16'd2048;

    localparam int MODE_SUB_BIT   = 0;
    localparam int MODE_CURVE_BIT = 1;
    localparam logic [1:0] MODE_FULL_CURVE = 2'd3;

    // quantizer modes carried in the low bits of each sub-block word
    localparam logic [1:0] QM_SPLIT  = 2'd0;
    localparam logic [1:0] QM_X64    = 2'd1;
    localparam logic [1:0] QM_X128   = 2'd2;
    localparam logic [1:0] QM_PACKED = 2'd3;

    localparam int CODE_W = 10;

    // reciprocal constants for the packed codes
    localparam logic [8:0]  DIV11_RECIP   = 9'd373;
    localparam int          DIV11_SHIFT   = 12;
    localparam logic [10:0] MOD176_RECIP  = 11'd1489;
    localparam int          MOD176_SHIFT  = 18;
    localparam logic [7:0]  MOD176_BASE   = 8'd176;

    typedef struct packed {
        logic [31:0] even_word;
        logic [31:0] odd_word;
    } block_t;

    typedef struct packed {
        logic [15:0] pixel_0;
        logic [15:0] pixel_1;
        logic [15:0] pixel_2;
        logic [15:0] pixel_3;
        logic [15:0] pixel_4;
        logic [15:0] pixel_5;
        logic [15:0] pixel_6;
        logic [15:0] pixel_7;
    } pixels_t;

    typedef struct packed {
        logic [1:0]              qmode;
        logic [3:0][CODE_W-1:0]  q;
    } codes_t;

endpackage

// ----- rtl/core/compressed_bayer_block_decoder.sv -----
// the start transfer is registered through v1_reg, v2_reg and v3_reg to the done strobe
// throughput: one block per cycle, busy is never raised
// stages: sub-block code extraction, dequantization, curve and offset
// done pulses for one cycle and the receiver cannot stall the pipeline
// reset (rst_n low, async): pipeline empties, mode = 1, offset = 2048
module compressed_bayer_block_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cbd_pkg::block_t  block,
    output logic             done,
    output cbd_pkg::pixels_t result,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [15:0]      wr_data
);

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [15:0] offset_reg;
    logic [15:0] offset_next;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    cbd_pkg::codes_t codes_even;
    cbd_pkg::codes_t codes_odd;
    cbd_pkg::codes_t codes_even_reg;
    cbd_pkg::codes_t codes_odd_reg;
    cbd_pkg::block_t words_reg;

    logic [3:0][15:0] deq_even;
    logic [3:0][15:0] deq_odd;
    logic [7:0][15:0] pix_next;
    logic [7:0][15:0] pix_reg;
    logic [7:0][15:0] fin;
    cbd_pkg::pixels_t result_reg;

    assign busy = 1'b0;

    always_comb
    begin
        mode_next = mode_reg;
        offset_next = offset_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                cbd_pkg::REG_MODE:   mode_next = wr_data[1:0];
                cbd_pkg::REG_OFFSET: offset_next = wr_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cbd_pkg::MODE_RESET;
            offset_reg <= cbd_pkg::OFFSET_RESET;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            offset_reg <= offset_next;
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // two sub-block lanes
    cbd_sub_decode u_dec_even (
        .word  (block.even_word),
        .codes (codes_even)
    );

    cbd_sub_decode u_dec_odd (
        .word  (block.odd_word),
        .codes (codes_odd)
    );

    always_ff @(posedge clk)
    begin
        codes_even_reg <= codes_even;
        codes_odd_reg <= codes_odd;
        words_reg <= block;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_deq
        cbd_dequant u_deq_even (
            .code  (codes_even_reg.q[i]),
            .qmode (codes_even_reg.qmode),
            .value (deq_even[i])
        );
        cbd_dequant u_deq_odd (
            .code  (codes_odd_reg.q[i]),
            .qmode (codes_odd_reg.qmode),
            .value (deq_odd[i])
        );
    end

    // merge lanes: interleave sub-blocks, or take bytes as high halves
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (mode_reg[cbd_pkg::MODE_SUB_BIT])
            begin
                pix_next[2 * i] = deq_even[i];
                pix_next[2 * i + 1] = deq_odd[i];
            end
            else
            begin
                pix_next[i] = {words_reg.even_word[8 * i +: 8], 8'h00};
                pix_next[i + 4] = {words_reg.odd_word[8 * i +: 8], 8'h00};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    for (genvar i = 0; i < 8; i++)
    begin : g_fin
        cbd_pixel_finish u_fin (
            .pixel_in  (pix_reg[i]),
            .mode      (mode_reg),
            .offset    (offset_reg),
            .pixel_out (fin[i])
        );
    end

    always_ff @(posedge clk)
    begin
        result_reg.pixel_0 <= fin[0];
        result_reg.pixel_1 <= fin[1];
        result_reg.pixel_2 <= fin[2];
        result_reg.pixel_3 <= fin[3];
        result_reg.pixel_4 <= fin[4];
        result_reg.pixel_5 <= fin[5];
        result_reg.pixel_6 <= fin[6];
        result_reg.pixel_7 <= fin[7];
    end

    assign done = v3_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/cbd_sub_decode.sv -----
module cbd_sub_decode (
    input  logic [31:0]    word,
    output cbd_pkg::codes_t codes
);

    logic [1:0]  qmode;
    logic [9:0]  f0;
    logic [9:0]  f1;
    logic [9:0]  f2;
    logic [9:0]  f3;
    logic [9:0]  a;
    logic [9:0]  b;
    logic [9:0]  p1;
    logic [9:0]  p2;
    logic [14:0] k0;
    logic [14:0] k1;
    logic [15:0] div_prod0;
    logic [15:0] div_prod1;
    logic [21:0] mod_prod0;
    logic [21:0] mod_prod1;
    logic [3:0]  quot0;
    logic [3:0]  quot1;
    logic [3:0]  mq0;
    logic [3:0]  mq1;
    logic [10:0] rem0;
    logic [10:0] rem1;
    logic [10:0] mod0;
    logic [10:0] mod1;

    assign qmode = word[1:0];
    assign f0 = {1'b0, word[10:2]};
    assign f1 = {3'b000, word[17:11]};
    assign f2 = {3'b000, word[24:18]};
    assign f3 = {3'b000, word[31:25]};

    // field prediction
    always_comb
    begin
        if (qmode == cbd_pkg::QM_X128 && f0 >= 10'd384)
        begin
            a = f0;
            b = f1 + 10'd384;
        end
        else if (f1 >= 10'd64)
        begin
            a = f0;
            b = f0 + f1 - 10'd64;
        end
        else
        begin
            a = f0 + 10'd64 - f1;
            b = f0;
        end
        p1 = (a >= 10'd64) ? a - 10'd64 : 10'd0;
        p2 = (b >= 10'd64) ? b - 10'd64 : 10'd0;
        if (qmode == cbd_pkg::QM_X128)
        begin
            if (p1 > 10'd384)
                p1 = 10'd384;
            if (p2 > 10'd384)
                p2 = 10'd384;
        end
    end

    // packed codes: divide by 11 and modulo 176 through reciprocals
    assign k0 = word[16:2];
    assign k1 = word[31:17];
    assign div_prod0 = 16'(k0[14:8]) * 16'(cbd_pkg::DIV11_RECIP);
    assign div_prod1 = 16'(k1[14:8]) * 16'(cbd_pkg::DIV11_RECIP);
    assign quot0 = 4'(div_prod0 >> cbd_pkg::DIV11_SHIFT);
    assign quot1 = 4'(div_prod1 >> cbd_pkg::DIV11_SHIFT);
    assign mod_prod0 = 22'(k0[14:4]) * 22'(cbd_pkg::MOD176_RECIP);
    assign mod_prod1 = 22'(k1[14:4]) * 22'(cbd_pkg::MOD176_RECIP);
    assign mq0 = 4'(mod_prod0 >> cbd_pkg::MOD176_SHIFT);
    assign mq1 = 4'(mod_prod1 >> cbd_pkg::MOD176_SHIFT);
    // quotient estimate may be one low, fix with one subtract
    assign rem0 = k0[14:4] - 11'(12'(mq0) * 12'(cbd_pkg::MOD176_BASE));
    assign rem1 = k1[14:4] - 11'(12'(mq1) * 12'(cbd_pkg::MOD176_BASE));
    assign mod0 = (rem0 >= 11'(cbd_pkg::MOD176_BASE))
                  ? rem0 - 11'(cbd_pkg::MOD176_BASE) : rem0;
    assign mod1 = (rem1 >= 11'(cbd_pkg::MOD176_BASE))
                  ? rem1 - 11'(cbd_pkg::MOD176_BASE) : rem1;

    always_comb
    begin
        codes.qmode = qmode;
        if (qmode == cbd_pkg::QM_PACKED)
        begin
            codes.q[0] = {2'b00, quot0, k0[3:0]};
            codes.q[1] = mod0[9:0];
            codes.q[2] = {2'b00, quot1, k1[3:0]};
            codes.q[3] = mod1[9:0];
        end
        else
        begin
            codes.q[0] = p1 + f2;
            codes.q[1] = a;
            codes.q[2] = b;
            codes.q[3] = p2 + f3;
        end
    end

endmodule

// ----- rtl/core/cbd_dequant.sv -----
module cbd_dequant (
    input  logic [cbd_pkg::CODE_W-1:0] code,
    input  logic [1:0]                 qmode,
    output logic [15:0]                value
);

    logic [18:0] q;
    logic [18:0] wide;

    assign q = 19'(code);

    always_comb
    begin
        unique case (qmode)
            cbd_pkg::QM_SPLIT:
                wide = (q < 19'd320) ? q << 4 : (q - 19'd160) << 5;
            cbd_pkg::QM_X64:
                wide = q << 6;
            cbd_pkg::QM_X128:
                wide = q << 7;
            cbd_pkg::QM_PACKED:
            begin
                if (q < 19'd94)
                    wide = q << 8;
                else if (((q - 19'd47) << 9) > 19'h0FFFF)
                    wide = 19'h0FFFF;
                else
                    wide = (q - 19'd47) << 9;
            end
            default:
                wide = '0;
        endcase
    end

    assign value = wide[15:0];

endmodule

// ----- rtl/core/cbd_pixel_finish.sv -----
module cbd_pixel_finish (
    input  logic [15:0] pixel_in,
    input  logic [1:0]  mode,
    input  logic [15:0] offset,
    output logic [15:0] pixel_out
);

    logic [15:0] curved;
    logic [16:0] sum;

    // piecewise expansion curve
    always_comb
    begin
        curved = pixel_in;
        if (mode[cbd_pkg::MODE_CURVE_BIT])
        begin
            if (mode == cbd_pkg::MODE_FULL_CURVE && pixel_in < 16'h4000)
                curved = pixel_in >> 2;
            else if (pixel_in < 16'h1000)
                curved = pixel_in >> 4;
            else if (pixel_in < 16'h1800)
                curved = (pixel_in - 16'h0800) >> 3;
            else if (pixel_in < 16'h3000)
                curved = (pixel_in - 16'h1000) >> 2;
            else if (pixel_in < 16'h6000)
                curved = (pixel_in - 16'h2000) >> 1;
            else if (pixel_in < 16'hC000)
                curved = pixel_in - 16'h4000;
            else
                curved = (pixel_in - 16'h8000) << 1;
        end
    end

    assign sum = {1'b0, curved} + {1'b0, offset};
    assign pixel_out = sum[16] ? 16'hFFFF : sum[15:0];

endmodule
